[src/ilp_pkg.sv]
// Shared types and constants for the integer literal parser.
// Holds the radix codes, character codes and the radix base lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  localparam int unsigned ACC_BITS = 63;
  localparam int unsigned VAL_BITS = 64;
  localparam int unsigned DIG_BITS = 4;
  localparam int unsigned BASE_BITS = 5;
  // The accumulator times sixteen plus a digit fits in this many bits.
  localparam int unsigned PROD_BITS = ACC_BITS + DIG_BITS;

  localparam logic [31:0] CH_0  = 32'd48;
  localparam logic [31:0] CH_9  = 32'd57;
  localparam logic [31:0] CH_UA = 32'd65;
  localparam logic [31:0] CH_UF = 32'd70;
  localparam logic [31:0] CH_LA = 32'd97;
  localparam logic [31:0] CH_LF = 32'd102;
  localparam logic [31:0] CH_UX = 32'd88;
  localparam logic [31:0] CH_LX = 32'd120;
  localparam logic [31:0] CH_UB = 32'd66;
  localparam logic [31:0] CH_LB = 32'd98;

  function automatic logic [BASE_BITS-1:0] radix_base(input radix_t rx);
    logic [BASE_BITS-1:0] b;
    case (rx)
      RX_DEC:  b = 5'd10;
      RX_HEX:  b = 5'd16;
      RX_BIN:  b = 5'd2;
      RX_OCT:  b = 5'd8;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[src/integer_literal_parser.sv]
// Top level of the streaming C-style integer literal parser.
// Depends on ilp_pkg for radix codes, character codes and the base lookup.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_character, in_last_char, in_negate
// out      out  out_valid / out_ready out_ok, out_value
//
// One character beat is taken every cycle unless a stalled result holds back a last
// character; the last character's beat passes the input register, then the result
// register. The rate is set by the accumulator loop: one 63-bit shift-add and range
// compare per character. Reset (synchronous, active low) empties both registers and
// clears state. A stalled result only holds back a following last character; other
// beats keep flowing behind it.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_parser
  import ilp_pkg::*;
#(
  parameter int unsigned CHAR_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [CHAR_BITS-1:0]        in_character,
  input  wire logic                        in_last_char,
  input  wire logic                        in_negate,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_ok,
  output logic signed [VAL_BITS-1:0]       out_value
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // Input register.
  logic                 s1_valid_r, s1_valid_nxt;
  logic [CHAR_BITS-1:0] s1_char_r;
  logic                 s1_last_r;
  logic                 s1_neg_r;

  // Parser state.
  phase_t                phase_r, phase_nxt;
  radix_t                radix_r, radix_nxt;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic                  failed_r, failed_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic                  out_neg_r;
  logic [ACC_BITS-1:0]   out_mag_r;

  logic in_fire;
  logic p_fire;

  // Step datapath.
  logic [31:0]           c_ext;
  radix_t                rx_eff;
  logic [ACC_BITS-1:0]   acc_eff;
  logic                  seen_eff;
  logic                  do_take;
  logic                  is_dec, is_uhex, is_lhex, found;
  logic [DIG_BITS-1:0]   dig;
  logic                  dig_ok;
  logic [PROD_BITS-1:0]  a_ext, mul, sum;
  logic                  over;
  logic                  res_ok;

  assign in_fire  = in_valid && in_ready;
  // A last character needs a free result register; anything else advances.
  assign p_fire   = s1_valid_r && !(s1_last_r && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || p_fire;

  assign c_ext = 32'(s1_char_r);

  always_comb begin
    rx_eff   = radix_r;
    acc_eff  = acc_r;
    seen_eff = seen_r;
    do_take  = 1'b0;
    phase_nxt = phase_r;
    case (phase_r)
      PH_FIRST: begin
        rx_eff   = RX_DEC;
        acc_eff  = '0;
        seen_eff = 1'b0;
        if (c_ext == CH_0 && !s1_last_r) begin
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = PH_DIGITS;
          do_take   = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (c_ext == CH_LX || c_ext == CH_UX) begin
          rx_eff = RX_HEX;
        end else if (c_ext == CH_LB || c_ext == CH_UB) begin
          rx_eff = RX_BIN;
        end else if (c_ext >= CH_0 && c_ext <= CH_9) begin
          rx_eff  = RX_OCT;
          do_take = 1'b1;
        end else begin
          // The leading zero counts as a digit; this character then fails.
          rx_eff   = RX_DEC;
          seen_eff = 1'b1;
          do_take  = 1'b1;
        end
      end
      default: begin
        do_take = 1'b1;
      end
    endcase
  end

  always_comb begin
    is_dec  = (c_ext >= CH_0) && (c_ext <= CH_9);
    is_uhex = (rx_eff == RX_HEX) && (c_ext >= CH_UA) && (c_ext <= CH_UF);
    is_lhex = (rx_eff == RX_HEX) && (c_ext >= CH_LA) && (c_ext <= CH_LF);
    if (is_dec) begin
      dig = DIG_BITS'(c_ext - CH_0);
    end else if (is_uhex) begin
      dig = DIG_BITS'(c_ext - CH_UA + 32'd10);
    end else begin
      dig = DIG_BITS'(c_ext - CH_LA + 32'd10);
    end
    found  = is_dec || is_uhex || is_lhex;
    dig_ok = found && ({1'b0, dig} < radix_base(rx_eff));

    a_ext = PROD_BITS'(acc_eff);
    case (rx_eff)
      RX_DEC:  mul = (a_ext << 3) + (a_ext << 1);
      RX_HEX:  mul = a_ext << 4;
      RX_BIN:  mul = a_ext << 1;
      RX_OCT:  mul = a_ext << 3;
      default: mul = a_ext;
    endcase
    sum  = mul + PROD_BITS'(dig);
    // Anything at or above bit 63 is past the largest signed 64-bit value.
    over = |sum[PROD_BITS-1:ACC_BITS];
  end

  always_comb begin
    radix_nxt  = rx_eff;
    acc_nxt    = acc_eff;
    seen_nxt   = seen_eff;
    failed_nxt = 1'b0;
    if (do_take) begin
      if (!dig_ok) begin
        failed_nxt = 1'b1;
      end else begin
        seen_nxt = 1'b1;
        if (over) begin
          failed_nxt = 1'b1;
        end else begin
          acc_nxt = sum[ACC_BITS-1:0];
        end
      end
    end
    res_ok = !failed_nxt && seen_nxt;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (p_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIRST;
      radix_r     <= RX_DEC;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      failed_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (p_fire) begin
        if (s1_last_r) begin
          phase_r  <= PH_FIRST;
          radix_r  <= RX_DEC;
          acc_r    <= '0;
          seen_r   <= 1'b0;
          failed_r <= 1'b0;
        end else if (!failed_r) begin
          phase_r  <= phase_nxt;
          radix_r  <= radix_nxt;
          acc_r    <= acc_nxt;
          seen_r   <= seen_nxt;
          failed_r <= failed_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last_char;
      s1_neg_r  <= in_negate;
    end
    if (p_fire && s1_last_r) begin
      // Once failed, the held state no longer matters; the result is zero.
      if (!failed_r && res_ok) begin
        out_ok_r  <= 1'b1;
        out_mag_r <= acc_nxt;
        out_neg_r <= s1_neg_r;
      end else begin
        out_ok_r  <= 1'b0;
        out_mag_r <= '0;
        out_neg_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_value = out_neg_r ? $signed(VAL_BITS'(0) - {1'b0, out_mag_r})
                               : $signed({1'b0, out_mag_r});

`ifndef SYNTHESIS
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIRST) |-> (acc_r == '0 && !seen_r && !failed_r))
    else $error("parser state not clean while waiting for a first character");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ZERO) |-> (acc_r == '0 && !failed_r))
    else $error("leading zero phase holds a value or a failure");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked last character");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_mag_r == '0 && !out_neg_r))
    else $error("failed result carries a nonzero value");
`endif

endmodule

`default_nettype wire

[tb/sv/literal_checker.sv]
// Checker for the integer literal parser: watches both channels, predicts each parse
// from the accepted character beats and compares every result beat with it.
// Depends on ilp_pkg for the radix codes and character codes.
`timescale 1ns / 1ps

module literal_checker
  import ilp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       in_character,
  input  logic              in_last_char,
  input  logic              in_negate,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_ok,
  input  logic signed [63:0] out_value,
  output int                mismatches,
  output int                parses_waiting
);

  typedef enum logic [1:0] {
    AWAIT_FIRST = 2'd0,
    AFTER_ZERO  = 2'd1,
    IN_DIGITS   = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } parse_t;

  localparam int unsigned     BAD_DIGIT = 99;
  localparam longint unsigned VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  scan_phase_t scan_phase;
  radix_t      scan_radix;
  logic [62:0] scan_acc;
  bit          scan_seen;
  bit          scan_bad;
  parse_t      expected_parses[$];
  parse_t      want;

  function automatic int unsigned digit_limit(input radix_t rx);
    int unsigned b;
    case (rx)
      RX_HEX:  b = 16;
      RX_BIN:  b = 2;
      RX_OCT:  b = 8;
      default: b = 10;
    endcase
    return b;
  endfunction

  // Letters only count as digits in hex; anything at or above the base is rejected.
  function automatic int unsigned digit_value(input logic [15:0] ch, input radix_t rx);
    int unsigned d;
    d = BAD_DIGIT;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
    end else if (rx == RX_HEX) begin
      if (ch >= CH_UA && ch <= CH_UF) d = 10 + (ch - CH_UA);
      else if (ch >= CH_LA && ch <= CH_LF) d = 10 + (ch - CH_LA);
    end
    if (d >= digit_limit(rx)) d = BAD_DIGIT;
    return d;
  endfunction

  task automatic clear_scan();
    scan_phase = AWAIT_FIRST;
    scan_radix = RX_DEC;
    scan_acc = '0;
    scan_seen = 0;
    scan_bad = 0;
  endtask

  task automatic accept_digit(input logic [15:0] ch);
    longint unsigned base;
    longint unsigned d;
    base = digit_limit(scan_radix);
    d = digit_value(ch, scan_radix);
    if (d == BAD_DIGIT) begin
      scan_bad = 1;
    end else begin
      scan_seen = 1;
      if ({1'b0, scan_acc} > (VAL_MAX - d) / base) scan_bad = 1;
      else scan_acc = 63'({1'b0, scan_acc} * base + d);
    end
  endtask

  task automatic scan_char(input logic [15:0] ch, input logic last, input logic neg);
    parse_t  res;
    longint  mag;
    if (!scan_bad) begin
      case (scan_phase)
        AWAIT_FIRST: begin
          scan_radix = RX_DEC;
          scan_acc = '0;
          scan_seen = 0;
          if (ch == CH_0 && !last) begin
            scan_phase = AFTER_ZERO;
          end else begin
            scan_phase = IN_DIGITS;
            accept_digit(ch);
          end
        end
        AFTER_ZERO: begin
          scan_phase = IN_DIGITS;
          if (ch == CH_LX || ch == CH_UX) begin
            scan_radix = RX_HEX;
          end else if (ch == CH_LB || ch == CH_UB) begin
            scan_radix = RX_BIN;
          end else if (ch >= CH_0 && ch <= CH_9) begin
            scan_radix = RX_OCT;
            accept_digit(ch);
          end else begin
            // The leading zero was a decimal digit; this character then fails.
            scan_radix = RX_DEC;
            scan_seen = 1;
            accept_digit(ch);
          end
        end
        default: accept_digit(ch);
      endcase
    end
    if (last) begin
      res.ok = !scan_bad && scan_seen;
      mag = longint'({1'b0, scan_acc});
      res.value = res.ok ? (neg ? -mag : mag) : 64'd0;
      expected_parses.push_back(res);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_parses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_parses.size() == 0) begin
          $error("result beat with no parse expected: out_ok=%0d out_value=%0d",
                 out_ok, out_value);
          mismatches = mismatches + 1;
        end else begin
          want = expected_parses.pop_front();
          if (out_ok !== want.ok) begin
            $error("out_ok: expected %0d, got %0d", want.ok, out_ok);
            mismatches = mismatches + 1;
          end
          if (out_value !== $signed(want.value)) begin
            $error("out_value: expected %0d, got %0d", $signed(want.value), out_value);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) scan_char(in_character, in_last_char, in_negate);
    end
    parses_waiting = expected_parses.size();
  end

endmodule

[tb/sv/integer_literal_parser_tb.sv]
// Top of the integer literal parser testbench: clock, reset, character and result
// stimulus with random idling, and the final verdict.
// Depends on ilp_pkg, integer_literal_parser and literal_checker.
`timescale 1ns / 1ps

module integer_literal_parser_tb;
  import ilp_pkg::*;

  localparam longint unsigned VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [15:0]       in_character;
  logic              in_last_char;
  logic              in_negate;
  logic              out_valid;
  logic              out_ready;
  logic              out_ok;
  logic signed [63:0] out_value;
  int                mismatches;
  int                parses_waiting;

  logic [15:0]       lit_text[$];
  bit                eager_send;
  int                chars_sent = 0;

  always #4 clk = ~clk;

  integer_literal_parser #(.CHAR_BITS(16)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_character(in_character),
    .in_last_char(in_last_char),
    .in_negate   (in_negate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_value   (out_value)
  );

  literal_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_character  (in_character),
    .in_last_char  (in_last_char),
    .in_negate     (in_negate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_value     (out_value),
    .mismatches    (mismatches),
    .parses_waiting(parses_waiting)
  );

  // Offers one character beat after a random gap and returns once it is taken.
  task automatic send_char(input logic [15:0] ch, input logic last, input logic neg);
    int gap;
    gap = eager_send ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    in_last_char <= last;
    in_negate <= neg;
    do @(posedge clk); while (!(in_valid && in_ready));
    chars_sent++;
  endtask

  task automatic send_literal();
    eager_send = ($urandom_range(0, 2) == 0);
    foreach (lit_text[i])
      send_char(lit_text[i], i == lit_text.size() - 1, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input string s);
    lit_text.delete();
    for (int i = 0; i < s.len(); i++) lit_text.push_back({8'd0, s[i]});
    send_literal();
  endtask

  function automatic logic [15:0] odd_char();
    logic [31:0] t;
    case ($urandom_range(0, 4))
      0:       t = CH_0 + $urandom_range(0, 9);
      1:       t = CH_UA + $urandom_range(0, 25);
      2:       t = CH_LA + $urandom_range(0, 25);
      3:       t = $urandom_range(0, 65535);
      // Low byte looks like a digit, but the upper bits are set.
      default: t = ($urandom_range(1, 255) << 8) | (CH_0 + $urandom_range(0, 9));
    endcase
    return t[15:0];
  endfunction

  task automatic add_number(input longint unsigned v, input radix_t rx);
    int unsigned digs[$];
    longint unsigned base;
    logic [31:0] t;
    base = radix_base(rx);
    do begin
      digs.push_front(int'(v % base));
      v = v / base;
    end while (v != 0);
    foreach (digs[i]) begin
      if (digs[i] < 10) t = CH_0 + digs[i];
      else t = ($urandom_range(0, 1) ? CH_UA : CH_LA) + digs[i] - 10;
      lit_text.push_back(t[15:0]);
    end
  endtask

  // Mostly well-formed literals with random values, some with one character
  // spoiled, and some plain noise.
  task automatic make_literal();
    int unsigned kind;
    int unsigned pos;
    radix_t rx;
    longint unsigned v;
    lit_text.delete();
    kind = $urandom_range(0, 9);
    rx = radix_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 1000);
      1:       v = {$urandom, $urandom};
      2:       v = VAL_MAX - 8 + $urandom_range(0, 16);
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if (rx == RX_BIN && v > 64'hFFFF && $urandom_range(0, 3) != 0) v = v >> 44;
    if (kind >= 8) begin
      repeat ($urandom_range(1, 5)) lit_text.push_back(odd_char());
    end else begin
      if (rx != RX_DEC) lit_text.push_back(CH_0[15:0]);
      if (rx == RX_HEX) lit_text.push_back($urandom_range(0, 1) ? CH_LX[15:0] : CH_UX[15:0]);
      if (rx == RX_BIN) lit_text.push_back($urandom_range(0, 1) ? CH_LB[15:0] : CH_UB[15:0]);
      if (rx != RX_DEC) repeat ($urandom_range(0, 1)) lit_text.push_back(CH_0[15:0]);
      add_number(v, rx);
      if (kind >= 6) begin
        pos = $urandom_range(0, lit_text.size() - 1);
        lit_text[pos] = odd_char();
      end
    end
  endtask

  // Result side: random stalls, eager stretches, and one long hold so the
  // parser backs up and stalls its input.
  initial begin
    int stall;
    int taken;
    bit eager_take;
    out_ready = 1'b0;
    taken = 0;
    eager_take = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken % 16 == 0) eager_take = ($urandom_range(0, 2) == 0);
      stall = eager_take ? 0 : $urandom_range(0, 15);
      if (taken == 40) stall = stall + 400;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_character = '0;
    in_last_char = 1'b0;
    in_negate = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("0");
    send_text("0x");
    send_text("0B");
    send_text("0z");
    send_text("089");
    send_text("0XaF");
    send_text("0b11");
    send_text("42");
    send_text("A");
    lit_text.delete();
    lit_text.push_back(16'hFFFF);
    send_literal();
    lit_text.delete();
    lit_text.push_back(16'h8031);
    send_literal();

    while (chars_sent < 700) begin
      make_literal();
      send_literal();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (parses_waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
